[src/vector_distance_unit_assert.svh]
// ----------------------------------------------------------------------------
// vector_distance_unit assertion macros
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_UNIT_ASSERT_SVH
`define VECTOR_DISTANCE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define VDU_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdu assertion failed: %m");
// next-cycle implication
`define VDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdu assertion failed: %m");
`else
`define VDU_ASSERT(label, clk, rst_n, ante, cons)
`define VDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/vdu_pkg.sv]
// ----------------------------------------------------------------------------
// vdu_pkg
// Widths, metric codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vdu_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = 48;

  localparam int DIFF_W     = DATA_WIDTH + 1;          // |a-b|, |a|+|b|
  localparam int SQR_W      = 2 * DIFF_W;              // squared difference
  localparam int SUM_W      = ((SQR_W > ACC_BITS) ? SQR_W : ACC_BITS) + 1;
  localparam int QUO_W      = FRAC_BITS + 1;           // quotient <= 1.0
  localparam int DREM_W     = DIFF_W + 1;              // divider remainder
  localparam int SQRT_HALF  = ACC_BITS / 2;
  localparam int ROOT_W     = SQRT_HALF + FRAC_BITS;   // root bits
  localparam int SREM_W     = ROOT_W + 2;              // root remainder
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(SQRT_STEPS);

  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ACC_BITS + 7) / 8) * 8;

  localparam int METRIC_W = 2;
  localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_CANBERRA  = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_CHEBYSHEV = 2'd2;
  localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd3;

  typedef struct packed {
    logic capture;      // take a new pair
    logic prep;         // square, divider setup
    logic div_step;     // one quotient bit
    logic accumulate;   // fold the pair into the running state
    logic sqrt_init;    // load root unit from accumulator
    logic sqrt_step;    // one root bit
    logic result_load;  // fill output register
  } vdu_cmd_t;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic                last;
    logic                den_zero;
    logic                out_busy;
  } vdu_sts_t;

endpackage

[src/vdu_datapath.sv]
// ----------------------------------------------------------------------------
// vdu_datapath
// Pair capture, squarer, bit-serial divider, digit-serial root, accumulators.
// ----------------------------------------------------------------------------
module vdu_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vdu_pkg::METRIC_W-1:0]          cfg_wdata_i,
  input  logic signed [vdu_pkg::DATA_WIDTH-1:0] elem_a_i,
  input  logic signed [vdu_pkg::DATA_WIDTH-1:0] elem_b_i,
  input  logic                                  last_pair_i,
  input  vdu_pkg::vdu_cmd_t                     cmd_i,
  output vdu_pkg::vdu_sts_t                     sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [vdu_pkg::ACC_BITS-1:0]          distance_o,
  output logic                                  zero_den_o
);

  localparam logic [vdu_pkg::ACC_BITS-1:0] ACC_MAX = '1;

  logic [vdu_pkg::METRIC_W-1:0] metric_q;
  logic [vdu_pkg::DIFF_W-1:0]   diff_q, den_q, max_q;
  logic                         last_q;
  logic [vdu_pkg::SQR_W-1:0]    sq_q;
  logic [vdu_pkg::DREM_W-1:0]   rem_q;
  logic [vdu_pkg::QUO_W-1:0]    quo_q;
  logic [vdu_pkg::ACC_BITS-1:0] acc_q, src_q, dist_q;
  logic                         err_q, first_q, out_valid_q, zden_q;
  logic [vdu_pkg::SREM_W-1:0]   srem_q;
  logic [vdu_pkg::ROOT_W-1:0]   root_q;

  // capture arithmetic
  logic signed [vdu_pkg::DIFF_W-1:0] dif_s;
  logic [vdu_pkg::DATA_WIDTH-1:0]    mag_a, mag_b;
  logic [vdu_pkg::DIFF_W-1:0]        diff_in, den_in;

  // divider
  logic                         div_ge;
  logic [vdu_pkg::DREM_W-1:0]   div_sub;

  // accumulator
  logic [vdu_pkg::SUM_W-1:0]    term, sum;
  logic [vdu_pkg::ACC_BITS-1:0] acc_sat;

  // root
  logic [vdu_pkg::SREM_W+1:0]   s_work, s_trial, s_diff;
  logic                         s_ge;

  logic [vdu_pkg::ACC_BITS-1:0] dist_d;

  function automatic logic [vdu_pkg::ACC_BITS-1:0] sat_shift(
    input logic [vdu_pkg::ACC_BITS-1:0] v
  );
    if (v[vdu_pkg::ACC_BITS-1:vdu_pkg::ACC_BITS-vdu_pkg::FRAC_BITS] != '0) begin
      return ACC_MAX;
    end
    return {v[vdu_pkg::ACC_BITS-vdu_pkg::FRAC_BITS-1:0], {vdu_pkg::FRAC_BITS{1'b0}}};
  endfunction

  always_comb begin
    dif_s   = vdu_pkg::DIFF_W'(elem_a_i) - vdu_pkg::DIFF_W'(elem_b_i);
    diff_in = dif_s[vdu_pkg::DIFF_W-1] ? vdu_pkg::DIFF_W'(-dif_s) : vdu_pkg::DIFF_W'(dif_s);
    mag_a   = elem_a_i[vdu_pkg::DATA_WIDTH-1] ? vdu_pkg::DATA_WIDTH'(-elem_a_i)
                                              : vdu_pkg::DATA_WIDTH'(elem_a_i);
    mag_b   = elem_b_i[vdu_pkg::DATA_WIDTH-1] ? vdu_pkg::DATA_WIDTH'(-elem_b_i)
                                              : vdu_pkg::DATA_WIDTH'(elem_b_i);
    den_in  = {1'b0, mag_a} + {1'b0, mag_b};
  end

  // restoring division, quotient MSB first
  assign div_sub = rem_q - {1'b0, den_q};
  assign div_ge  = rem_q >= {1'b0, den_q};

  always_comb begin
    case (metric_q)
      vdu_pkg::METRIC_EUCLID:   term = vdu_pkg::SUM_W'(sq_q);
      vdu_pkg::METRIC_CANBERRA: term = vdu_pkg::SUM_W'(quo_q);
      default:                  term = vdu_pkg::SUM_W'(diff_q);
    endcase
    sum     = vdu_pkg::SUM_W'(acc_q) + term;
    acc_sat = (sum[vdu_pkg::SUM_W-1:vdu_pkg::ACC_BITS] != '0) ? ACC_MAX
                                                          : sum[vdu_pkg::ACC_BITS-1:0];
  end

  // square root, one result bit per step
  assign s_work  = {srem_q, src_q[vdu_pkg::ACC_BITS-1 -: 2]};
  assign s_trial = (vdu_pkg::SREM_W+2)'({root_q, 2'b01});
  assign s_diff  = s_work - s_trial;
  assign s_ge    = s_work >= s_trial;

  always_comb begin
    case (metric_q)
      vdu_pkg::METRIC_EUCLID:    dist_d = vdu_pkg::ACC_BITS'(root_q);
      vdu_pkg::METRIC_CANBERRA:  dist_d = acc_q;
      vdu_pkg::METRIC_CHEBYSHEV: dist_d = sat_shift(vdu_pkg::ACC_BITS'(max_q));
      default:                   dist_d = sat_shift(acc_q);
    endcase
    if (err_q) begin
      dist_d = '0;
    end
  end

  // control-visible state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q    <= vdu_pkg::METRIC_EUCLID;
      acc_q       <= '0;
      max_q       <= '0;
      err_q       <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        metric_q <= cfg_wdata_i;
      end
      if (cmd_i.capture && first_q) begin
        acc_q   <= '0;
        max_q   <= '0;
        err_q   <= 1'b0;
        first_q <= 1'b0;
      end
      if (cmd_i.accumulate) begin
        case (metric_q)
          vdu_pkg::METRIC_CANBERRA: begin
            if (den_q == '0) begin
              err_q <= 1'b1;
            end else begin
              acc_q <= acc_sat;
            end
          end
          vdu_pkg::METRIC_CHEBYSHEV: begin
            if (diff_q > max_q) begin
              max_q <= diff_q;
            end
          end
          default: acc_q <= acc_sat;
        endcase
      end
      if (cmd_i.result_load) begin
        first_q     <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      diff_q <= diff_in;
      den_q  <= den_in;
      last_q <= last_pair_i;
    end
    if (cmd_i.prep) begin
      sq_q  <= vdu_pkg::SQR_W'(diff_q * diff_q);
      rem_q <= {1'b0, diff_q};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? {div_sub[vdu_pkg::DREM_W-2:0], 1'b0}
                      : {rem_q[vdu_pkg::DREM_W-2:0], 1'b0};
      quo_q <= {quo_q[vdu_pkg::QUO_W-2:0], div_ge};
    end
    if (cmd_i.sqrt_init) begin
      src_q  <= acc_q;
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      src_q  <= {src_q[vdu_pkg::ACC_BITS-3:0], 2'b00};
      srem_q <= s_ge ? s_diff[vdu_pkg::SREM_W-1:0] : s_work[vdu_pkg::SREM_W-1:0];
      root_q <= {root_q[vdu_pkg::ROOT_W-2:0], s_ge};
    end
    if (cmd_i.result_load) begin
      dist_q <= dist_d;
      zden_q <= err_q;
    end
  end

  assign sts_o.metric   = metric_q;
  assign sts_o.last     = last_q;
  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign zero_den_o  = zden_q;

endmodule

[src/vdu_ctrl.sv]
// ----------------------------------------------------------------------------
// vdu_ctrl
// Sequencer: capture, prepare, divide or root iterations, accumulate, result.
// ----------------------------------------------------------------------------
`include "vector_distance_unit_assert.svh"

module vdu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vdu_pkg::vdu_sts_t sts_i,
  output vdu_pkg::vdu_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_SQLD = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [vdu_pkg::CNT_W-1:0] DIV_LAST  = vdu_pkg::CNT_W'(vdu_pkg::DIV_STEPS - 1);
  localparam logic [vdu_pkg::CNT_W-1:0] SQRT_LAST = vdu_pkg::CNT_W'(vdu_pkg::SQRT_STEPS - 1);

  logic [2:0]                state_q, state_d;
  logic [vdu_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        if (sts_i.metric == vdu_pkg::METRIC_CANBERRA && !sts_i.den_zero) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        if (!sts_i.last) begin
          state_d = ST_IDLE;
        end else if (sts_i.metric == vdu_pkg::METRIC_EUCLID) begin
          state_d = ST_SQLD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SQLD: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `VDU_ASSERT(a_div_bound, clk_i, rst_ni, state_q == ST_DIV, cnt_q <= DIV_LAST)
  `VDU_ASSERT(a_sqrt_bound, clk_i, rst_ni, state_q == ST_SQRT, cnt_q <= SQRT_LAST)
  `VDU_ASSERT(a_done_on_last, clk_i, rst_ni, state_q == ST_DONE, sts_i.last)
  `VDU_ASSERT_NEXT(a_div_exit, clk_i, rst_ni, state_q == ST_DIV && cnt_q == DIV_LAST, state_q == ST_ACC)

endmodule

[src/vector_distance_unit.sv]
// ----------------------------------------------------------------------------
// vector_distance_unit: Euclidean / Canberra / Chebyshev / Manhattan distance
// Each pair is captured, prepared and accumulated; Canberra adds a 17-step divider.
// The last pair then loads the output register; Euclidean first runs the
// 40-step digit-serial root. The output register lets the next pair in early.
// Async active-low reset: metric Euclidean, accumulators clear, no result.
// ----------------------------------------------------------------------------
module vector_distance_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  // metric register (0 Euclidean, 1 Canberra, 2 Chebyshev, 3 Manhattan)
  input  logic                               cfg_we_i,
  input  logic [vdu_pkg::METRIC_W-1:0]       cfg_wdata_i,

  // element pair stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vdu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // elem_a, elem_b
  input  logic                               s_axis_tlast,   // last_pair

  // distance stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [vdu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // distance
  output logic                               m_axis_tuser    // zero_denominator
);

  vdu_pkg::vdu_cmd_t cmd;
  vdu_pkg::vdu_sts_t sts;

  logic [vdu_pkg::ACC_BITS-1:0] distance;

  // Controller: one pair per transaction, walks the pair through prepare,
  // optional divider iterations, accumulate, and (on the last pair) the
  // Euclidean root iterations and the output register load.
  vdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: elem_a in the low half of tdata, elem_b above it.
  vdu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_a_i    (s_axis_tdata[vdu_pkg::DATA_WIDTH-1:0]),
    .elem_b_i    (s_axis_tdata[2*vdu_pkg::DATA_WIDTH-1:vdu_pkg::DATA_WIDTH]),
    .last_pair_i (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .distance_o  (distance),
    .zero_den_o  (m_axis_tuser)
  );

  // distance zero-extended to whole bytes
  assign m_axis_tdata = vdu_pkg::OUT_TDATA_W'(distance);

endmodule
